### hw/rtl/kpss_pkg.sv
//------------------------------------------------------------------------------
// kpss_pkg
// Shared types, constants and helper functions for the keypad scanner
// with seven-segment display.
//------------------------------------------------------------------------------
`default_nettype none

package kpss_pkg;

  // display size default and fixed field widths
  localparam int DIGIT_COUNT_DEFAULT = 4;
  localparam int SAMPLE_W            = 8;
  localparam int CODE_W              = 6;
  localparam int DIGIT_W             = 4;
  localparam int SELECT_W            = 8;
  localparam int SEGMENT_W           = 8;

  // idle port patterns of the two scanned rows
  localparam logic [SAMPLE_W-1:0] IDLE_ROW_A = 8'hBF;
  localparam logic [SAMPLE_W-1:0] IDLE_ROW_B = 8'h7F;

  // input transaction payload
  typedef struct packed {
    logic [SAMPLE_W-1:0] row_a_first_sample;
    logic [SAMPLE_W-1:0] row_a_second_sample;
    logic [SAMPLE_W-1:0] row_b_first_sample;
    logic [SAMPLE_W-1:0] row_b_second_sample;
  } scan_item_t;

  // output transaction payload
  typedef struct packed {
    logic [SELECT_W-1:0]  digit_enable;
    logic [SEGMENT_W-1:0] segment_pattern;
    logic                 send_valid;
    logic [CODE_W-1:0]    send_byte;
  } result_item_t;

  // low two decimal digits of a key code
  typedef struct packed {
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] ones;
  } digit_pair_t;

  // pack raw bits 7:6 into code bits 5:4 and raw bits 5:4 into code bits 1:0
  function automatic logic [CODE_W-1:0] pack_code(input logic [SAMPLE_W-1:0] raw);
    pack_code = {raw[7:6], 2'b00, raw[5:4]};
  endfunction

  // a packed code is at most 51, so the tens digit is found by compares
  function automatic digit_pair_t split_code(input logic [CODE_W-1:0] code);
    digit_pair_t        res;
    logic [CODE_W-1:0]  base;
    if (code >= CODE_W'(50)) begin
      res.tens = DIGIT_W'(5);
      base     = CODE_W'(50);
    end else if (code >= CODE_W'(40)) begin
      res.tens = DIGIT_W'(4);
      base     = CODE_W'(40);
    end else if (code >= CODE_W'(30)) begin
      res.tens = DIGIT_W'(3);
      base     = CODE_W'(30);
    end else if (code >= CODE_W'(20)) begin
      res.tens = DIGIT_W'(2);
      base     = CODE_W'(20);
    end else if (code >= CODE_W'(10)) begin
      res.tens = DIGIT_W'(1);
      base     = CODE_W'(10);
    end else begin
      res.tens = DIGIT_W'(0);
      base     = CODE_W'(0);
    end
    res.ones   = DIGIT_W'(code - base);
    split_code = res;
  endfunction

  // active-low seven-segment code of one decimal digit
  function automatic logic [SEGMENT_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
    logic [SEGMENT_W-1:0] seg;
    unique case (digit)
      4'd0:    seg = 8'hC0;
      4'd1:    seg = 8'hF9;
      4'd2:    seg = 8'hA4;
      4'd3:    seg = 8'hB0;
      4'd4:    seg = 8'h99;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h82;
      4'd7:    seg = 8'hF8;
      4'd8:    seg = 8'h80;
      4'd9:    seg = 8'h90;
      default: seg = 8'hFF;
    endcase
    seg_code = seg;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/kpss_scan_if.sv
//------------------------------------------------------------------------------
// kpss_scan_if
// Valid/ready channel carrying one tick's four keypad port samples.
//------------------------------------------------------------------------------
`default_nettype none

interface kpss_scan_if
  import kpss_pkg::*;
;
  logic       valid;
  logic       ready;
  scan_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/kpss_result_if.sv
//------------------------------------------------------------------------------
// kpss_result_if
// Valid/ready channel carrying one tick's display drive and send code.
//------------------------------------------------------------------------------
`default_nettype none

interface kpss_result_if
  import kpss_pkg::*;
;
  logic         valid;
  logic         ready;
  result_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/keypad_scan_to_seven_segment_unit.sv
//------------------------------------------------------------------------------
// keypad_scan_to_seven_segment_unit
// Two-row keypad scan decision, key code packing and multiplexed
// seven-segment display drive, one result per scan tick.
//------------------------------------------------------------------------------
// Every scan transaction produces exactly one result transaction, registered
// in the cycle after it is accepted. The scan decision, the digit split and the
// segment lookup sit in one combinational step between the input handshake
// and the result register, so a new transaction is taken every cycle as long
// as the result register is empty or is being emptied in the same cycle; a
// stalled result blocks only the next acceptance. The display position walks
// through DIGIT_COUNT positions (2 to 8), most significant digit first, and
// the digit shown already reflects a key code confirmed in the same tick.
`default_nettype none

module keypad_scan_to_seven_segment_unit
  import kpss_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  kpss_scan_if.sink         scan,
  kpss_result_if.source     result
);

  localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  // state
  logic [SAMPLE_W-1:0] prev_raw;
  logic [SAMPLE_W-1:0] prev_raw_next;
  logic [POS_W-1:0]    pos;
  logic [POS_W-1:0]    pos_next;
  logic [DIGIT_W-1:0]  ones;
  logic [DIGIT_W-1:0]  tens;
  digit_pair_t         digits_next;

  // result register
  logic         out_valid;
  result_item_t out_data;
  result_item_t out_data_next;

  logic accept;

  assign scan.ready   = ~out_valid | result.ready;
  assign accept       = scan.valid & scan.ready;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  // scan decision, digit update and display drive for one tick
  always_comb begin
    logic [SAMPLE_W-1:0] second;
    logic [SAMPLE_W-1:0] idle;
    logic                active;
    logic                sent;
    logic [CODE_W-1:0]   code;
    logic [DIGIT_W-1:0]  shown;

    second = scan.data.row_b_second_sample;
    idle   = IDLE_ROW_B;
    active = 1'b0;
    if (scan.data.row_a_first_sample != IDLE_ROW_A) begin
      second = scan.data.row_a_second_sample;
      idle   = IDLE_ROW_A;
      active = 1'b1;
    end else if (scan.data.row_b_first_sample != IDLE_ROW_B) begin
      active = 1'b1;
    end

    sent = active && (second != idle) && (second != prev_raw);
    code = pack_code(second);

    // previous code: replaced on a press, kept on a bounce, cleared when idle
    if (sent) begin
      prev_raw_next = second;
    end else if (active) begin
      prev_raw_next = prev_raw;
    end else begin
      prev_raw_next = '0;
    end

    if (sent) begin
      digits_next = split_code(code);
    end else begin
      digits_next.tens = tens;
      digits_next.ones = ones;
    end

    // digits above tens are always zero for a code of at most 51
    if (pos == POS_W'(DIGIT_COUNT - 1)) begin
      shown = digits_next.ones;
    end else if (pos == POS_W'(DIGIT_COUNT - 2)) begin
      shown = digits_next.tens;
    end else begin
      shown = '0;
    end

    out_data_next.digit_enable    = ~(SELECT_W'(1) << pos);
    out_data_next.segment_pattern = seg_code(shown);
    out_data_next.send_valid      = sent;
    out_data_next.send_byte       = sent ? code : '0;

    // display position wraps at the digit count
    if (pos == POS_W'(DIGIT_COUNT - 1)) begin
      pos_next = '0;
    end else begin
      pos_next = pos + POS_W'(1);
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw  <= '0;
      pos       <= '0;
      ones      <= '0;
      tens      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        prev_raw  <= prev_raw_next;
        pos       <= pos_next;
        ones      <= digits_next.ones;
        tens      <= digits_next.tens;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded on each accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= out_data_next;
    end
  end

endmodule

`default_nettype wire
